// File: src/resp_reply_parser_core_defines.svh
// Assertion macros for the files that check their own behavior.
// Each macro expects a clock named clk and an active-low reset named arst_n.
`ifndef RESP_REPLY_PARSER_CORE_DEFINES_SVH
`define RESP_REPLY_PARSER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RRP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define RRP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/rrp_pkg.sv
`timescale 1ns / 1ps

package rrp_pkg;

	// Largest bulk payload length that is accepted.
	localparam int unsigned MAX_PAYLOAD = 65535;

	// Length accumulator: one bit above the largest length marks overflow.
	localparam int unsigned LEN_W    = 17;
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_PAYLOAD);
	localparam logic [LEN_W-1:0] LEN_SAT = LEN_W'(MAX_PAYLOAD + 1);

	// Width of the packed result data on the output stream.
	localparam int unsigned TDATA_W = 32;

	// Protocol characters.
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COLON  = 8'h3A;
	localparam logic [7:0] CH_O      = 8'h4F;
	localparam logic [7:0] CH_K      = 8'h4B;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_N      = 8'h4E;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_NINE   = 8'h39;

	// Request kinds.
	localparam logic [2:0] RQ_SET   = 3'd0;
	localparam logic [2:0] RQ_AUTH  = 3'd1;
	localparam logic [2:0] RQ_CHECK = 3'd2;
	localparam logic [2:0] RQ_GET   = 3'd3;
	localparam logic [2:0] RQ_DEL   = 3'd4;

	// Completion status codes.
	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_TYPE   = 2'd1;
	localparam logic [1:0] ST_SERVER = 2'd2;
	localparam logic [1:0] ST_PROTO  = 2'd3;

	// Result item kinds.
	localparam logic ITEM_PAYLOAD = 1'b0;
	localparam logic ITEM_STATUS  = 1'b1;

	// One result item.
	typedef struct packed {
		logic        item_type;
		logic [7:0]  payload_byte;
		logic [1:0]  status;
		logic        null_reply;
		logic [15:0] payload_length;
	} rrp_result_t;

endpackage

// File: src/rrp_parse.sv
`timescale 1ns / 1ps

module rrp_parse (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         data_byte,
	input  logic [2:0]         expected_reply,
	output logic               res_valid,
	output rrp_pkg::rrp_result_t res
);
	import rrp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LINE,
		PH_END,
		PH_PAYLOAD,
		PH_TCR,
		PH_TLF
	} phase_t;

	typedef enum logic [2:0] {
		MK_OTHER,
		MK_SIMPLE,
		MK_ERROR,
		MK_BULK,
		MK_INT
	} marker_t;

	phase_t            phase_q, phase_d;
	marker_t           marker_q, marker_d;
	logic [2:0]        request_q, request_d;
	logic [3:0]        line_count_q, line_count_d;
	logic [2:0]        flags_q, flags_d;
	logic [LEN_W-1:0]  length_q, length_d;
	logic [15:0]       left_q, left_d;

	logic              is_digit;
	logic [19:0]       length_next;
	logic              simple_ok;

	// Decimal length step: times ten plus the new digit, with saturation.
	assign is_digit    = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
	assign length_next = 20'({length_q, 3'b000}) + 20'({length_q, 1'b0})
		+ 20'(data_byte[3:0]);

	// A simple line matches only the exact text for its request.
	assign simple_ok = ((line_count_q == 4'd2) && flags_q[0]
			&& ((request_q == RQ_SET) || (request_q == RQ_AUTH)))
		|| ((line_count_q == 4'd4) && flags_q[1] && (request_q == RQ_CHECK));

	// Next state and result for the byte on the input.
	always_comb begin
		phase_d      = phase_q;
		marker_d     = marker_q;
		request_d    = request_q;
		line_count_d = line_count_q;
		flags_d      = flags_q;
		length_d     = length_q;
		left_d       = left_q;
		res_valid    = 1'b0;
		res          = '0;
		res.item_type = ITEM_STATUS;

		case (phase_q)
			PH_IDLE: begin
				request_d    = expected_reply;
				line_count_d = '0;
				length_d     = '0;
				left_d       = '0;
				flags_d      = '0;
				case (data_byte)
					CH_PLUS: begin
						marker_d = MK_SIMPLE;
						flags_d  = 3'b011;
					end
					CH_MINUS:  marker_d = MK_ERROR;
					CH_DOLLAR: marker_d = MK_BULK;
					CH_COLON:  marker_d = MK_INT;
					default:   marker_d = MK_OTHER;
				endcase
				phase_d = (data_byte == CH_CR) ? PH_END : PH_LINE;
			end

			PH_LINE: begin
				if (data_byte == CH_CR) begin
					phase_d = PH_END;
				end else begin
					if (marker_q == MK_SIMPLE) begin
						if (!(((line_count_q == 4'd0) && (data_byte == CH_O))
								|| ((line_count_q == 4'd1) && (data_byte == CH_K)))) begin
							flags_d[0] = 1'b0;
						end
						if (!(((line_count_q == 4'd0) && (data_byte == CH_P))
								|| ((line_count_q == 4'd1) && (data_byte == CH_O))
								|| ((line_count_q == 4'd2) && (data_byte == CH_N))
								|| ((line_count_q == 4'd3) && (data_byte == CH_G)))) begin
							flags_d[1] = 1'b0;
						end
					end else if (marker_q == MK_BULK) begin
						if ((line_count_q == 4'd0) && (data_byte == CH_MINUS)) begin
							flags_d[0] = 1'b1;
						end
						if ((line_count_q == 4'd1) && (data_byte == CH_ONE)) begin
							flags_d[2] = 1'b1;
						end
						if (is_digit) begin
							if ((length_q > LEN_MAX) || (length_next > 20'(MAX_PAYLOAD))) begin
								length_d = LEN_SAT;
							end else begin
								length_d = length_next[LEN_W-1:0];
							end
						end else begin
							flags_d[1] = 1'b1;
						end
					end
					if (line_count_q != 4'hF) begin
						line_count_d = line_count_q + 4'd1;
					end
				end
			end

			PH_END: begin
				res_valid = 1'b1;
				phase_d   = PH_IDLE;
				case (marker_q)
					MK_SIMPLE: res.status = simple_ok ? ST_OK : ST_TYPE;
					MK_ERROR:  res.status = ST_SERVER;
					MK_INT:    res.status = (request_q == RQ_DEL) ? ST_OK : ST_TYPE;
					MK_BULK: begin
						if (request_q != RQ_GET) begin
							res.status = ST_TYPE;
						end else if (flags_q[0] && flags_q[2]) begin
							res.status     = ST_OK;
							res.null_reply = 1'b1;
						end else if (flags_q[1] || (line_count_q == 4'd0)
								|| (length_q > LEN_MAX)) begin
							res.status = ST_PROTO;
						end else begin
							// Valid length: pass the payload before the status.
							res_valid = 1'b0;
							left_d    = length_q[15:0];
							phase_d   = (length_q != '0) ? PH_PAYLOAD : PH_TCR;
						end
					end
					default: res.status = ST_PROTO;
				endcase
			end

			PH_PAYLOAD: begin
				res_valid        = 1'b1;
				res.item_type    = ITEM_PAYLOAD;
				res.payload_byte = data_byte;
				left_d           = left_q - 16'd1;
				if (left_q == 16'd1) begin
					phase_d = PH_TCR;
				end
			end

			PH_TCR: begin
				phase_d = PH_TLF;
			end

			PH_TLF: begin
				res_valid          = 1'b1;
				res.status         = ST_OK;
				res.payload_length = length_q[15:0];
				phase_d            = PH_IDLE;
			end

			default: begin
				phase_d = PH_IDLE;
			end
		endcase
	end

	// Parser state, advanced once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			marker_q     <= MK_OTHER;
			request_q    <= '0;
			line_count_q <= '0;
			flags_q      <= '0;
			length_q     <= '0;
			left_q       <= '0;
		end else if (take) begin
			phase_q      <= phase_d;
			marker_q     <= marker_d;
			request_q    <= request_d;
			line_count_q <= line_count_d;
			flags_q      <= flags_d;
			length_q     <= length_d;
			left_q       <= left_d;
		end
	end

endmodule

// File: src/rrp_obuf.sv
`timescale 1ns / 1ps

module rrp_obuf (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rrp_pkg::rrp_result_t push_data,
	output logic                 space,
	output logic                 out_valid,
	input  logic                 out_ready,
	output rrp_pkg::rrp_result_t out_data
);
	import rrp_pkg::*;

	logic        out_valid_q;
	rrp_result_t out_data_q;
	logic        skid_valid_q;
	rrp_result_t skid_data_q;
	logic        pop;

	// New requests are taken while the skid slot is free.
	assign space     = !skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;
	assign pop       = out_valid_q && out_ready;

	// Occupancy of the output register and the skid slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= push;
			end
		end else if (!out_valid_q) begin
			out_valid_q <= push;
		end else if (push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Result data follows the occupancy decisions above.
	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				out_data_q <= skid_data_q;
			end else begin
				out_data_q <= push_data;
			end
		end else if (!out_valid_q) begin
			out_data_q <= push_data;
		end else if (push) begin
			skid_data_q <= push_data;
		end
	end

endmodule

// File: src/resp_reply_parser_core.sv
// Reply parser for a key-value server stream. One reply byte enters per request on the
// input stream, with the kind of request it answers in tuser (sampled on the first byte
// of each reply). A byte is accepted in every cycle while the two-entry output stage has
// room; its result, if any, is registered there before it shows on the output stream.
// A bulk reply to a get with a valid length gives one payload item per payload byte,
// then a status item with the length; every other reply gives a single status item on
// the byte after its first CR. MAX_PAYLOAD in the package limits the payload length.
`timescale 1ns / 1ps

`include "resp_reply_parser_core_defines.svh"

module resp_reply_parser_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
	input  logic [2:0]  s_axis_tuser,  // [2:0] expected_reply
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [rrp_pkg::TDATA_W-1:0] m_axis_tdata,
	// m_axis_tdata: [7:0] payload_byte, [9:8] status, [10] null_reply,
	// [26:11] payload_length, [31:27] zero
	output logic        m_axis_tuser   // [0] item_type
);
	import rrp_pkg::*;

	logic        take;
	logic        res_valid;
	rrp_result_t res;
	rrp_result_t out_res;

	assign take = s_axis_tvalid && s_axis_tready;

	// Reply state machine.
	rrp_parse u_parse (
		.clk            (clk),
		.arst_n         (arst_n),
		.take           (take),
		.data_byte      (s_axis_tdata),
		.expected_reply (s_axis_tuser),
		.res_valid      (res_valid),
		.res            (res)
	);

	// Output register with skid slot.
	rrp_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (take && res_valid),
		.push_data (res),
		.space     (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_data  (out_res)
	);

	// Pack the result fields onto the stream.
	assign m_axis_tuser = out_res.item_type;
	assign m_axis_tdata = {5'b00000, out_res.payload_length, out_res.null_reply,
		out_res.status, out_res.payload_byte};

	// The skid slot fills only behind a held result.
	`RRP_ASSERT_NOW(a_skid_behind_out, !s_axis_tready, m_axis_tvalid,
		"skid slot holds a result while the output register is empty")

	// A full buffer drains one entry when the output is taken.
	`RRP_ASSERT_NEXT(a_skid_drains, !s_axis_tready && m_axis_tready,
		s_axis_tready && m_axis_tvalid, "skid slot did not drain into the output register")

	// Payload items carry no status, null flag or length.
	`RRP_ASSERT_NOW(a_payload_clean, m_axis_tvalid && (m_axis_tuser == ITEM_PAYLOAD),
		m_axis_tdata[26:8] == 19'd0, "payload item with status fields set")

	// A null reply or a nonzero length only comes with an ok status.
	`RRP_ASSERT_NOW(a_status_ok, m_axis_tvalid && (m_axis_tdata[10]
		|| (m_axis_tdata[26:11] != 16'd0)), m_axis_tdata[9:8] == ST_OK,
		"null reply or length given with an error status")

endmodule

// File: sim/resp_reply_parser_core_checker.sv
`timescale 1ns / 1ps

module resp_reply_parser_core_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	input  logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,
	input  logic [2:0]                    s_axis_tuser,
	input  logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	input  logic [rrp_pkg::TDATA_W-1:0]   m_axis_tdata,
	input  logic                          m_axis_tuser,
	output int                            fail_count,
	output int                            pending
);

	import rrp_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LINE,
		PH_END,
		PH_PAYLOAD,
		PH_TCR,
		PH_TLF
	} parse_phase_t;

	typedef enum logic [2:0] {
		MK_OTHER,
		MK_SIMPLE,
		MK_ERROR,
		MK_BULK,
		MK_INT
	} reply_kind_t;

	// Parser state as the predictor tracks it.
	parse_phase_t       parse_phase;
	reply_kind_t        reply_kind;
	logic [2:0]         req_kind;
	logic [3:0]         line_len;
	logic [2:0]         line_flags;
	logic [LEN_W-1:0]   len_acc;
	logic [15:0]        bytes_left;

	// Results owed by the parser, oldest first.
	rrp_result_t        results_due[$];

	// Advances the predicted parser by one reply byte and gives the result it owes, if any.
	function automatic void parse_reply_byte(input logic [7:0] b, input logic [2:0] kind,
			output bit produced, output rrp_result_t res);
		logic [4:0]  pos;
		int unsigned acc;
		logic        simple_ok;
		produced = 1'b0;
		res = '0;
		case (parse_phase)
			PH_IDLE: begin
				req_kind = kind;
				line_len = '0;
				len_acc = '0;
				bytes_left = '0;
				line_flags = '0;
				case (b)
					CH_PLUS: begin
						reply_kind = MK_SIMPLE;
						line_flags = 3'b011;
					end
					CH_MINUS:  reply_kind = MK_ERROR;
					CH_DOLLAR: reply_kind = MK_BULK;
					CH_COLON:  reply_kind = MK_INT;
					default:   reply_kind = MK_OTHER;
				endcase
				parse_phase = (b == CH_CR) ? PH_END : PH_LINE;
			end
			PH_LINE: begin
				if (b == CH_CR) begin
					parse_phase = PH_END;
				end else begin
					pos = 5'(line_len) + 5'd1;
					if (reply_kind == MK_SIMPLE) begin
						// Keep only the candidates that still spell OK or PONG.
						if (!((pos == 5'd1 && b == CH_O) || (pos == 5'd2 && b == CH_K)))
							line_flags[0] = 1'b0;
						if (!((pos == 5'd1 && b == CH_P) || (pos == 5'd2 && b == CH_O) ||
								(pos == 5'd3 && b == CH_N) || (pos == 5'd4 && b == CH_G)))
							line_flags[1] = 1'b0;
					end else if (reply_kind == MK_BULK) begin
						if (pos == 5'd1 && b == CH_MINUS)
							line_flags[0] = 1'b1;
						if (pos == 5'd2 && b == CH_ONE)
							line_flags[2] = 1'b1;
						if (b >= CH_ZERO && b <= CH_NINE) begin
							// Decimal length, pinned one above the largest once it overflows.
							if (len_acc <= LEN_MAX) begin
								acc = 32'(len_acc) * 10 + 32'(b - CH_ZERO);
								len_acc = (acc > MAX_PAYLOAD) ? LEN_SAT : LEN_W'(acc);
							end
						end else begin
							line_flags[1] = 1'b1;
						end
					end
					if (line_len != 4'd15)
						line_len = line_len + 4'd1;
				end
			end
			PH_END: begin
				produced = 1'b1;
				res.item_type = ITEM_STATUS;
				res.status = ST_OK;
				parse_phase = PH_IDLE;
				case (reply_kind)
					MK_SIMPLE: begin
						simple_ok = (line_len == 4'd2 && line_flags[0] &&
								(req_kind == RQ_SET || req_kind == RQ_AUTH)) ||
								(line_len == 4'd4 && line_flags[1] && req_kind == RQ_CHECK);
						res.status = simple_ok ? ST_OK : ST_TYPE;
					end
					MK_ERROR: res.status = ST_SERVER;
					MK_INT:   res.status = (req_kind == RQ_DEL) ? ST_OK : ST_TYPE;
					MK_BULK: begin
						if (req_kind != RQ_GET) begin
							res.status = ST_TYPE;
						end else if (line_flags[0] && line_flags[2]) begin
							res.null_reply = 1'b1;
						end else if (line_flags[1] || line_len == 4'd0 || len_acc > LEN_MAX) begin
							res.status = ST_PROTO;
						end else begin
							// A good length: the payload follows and the status waits for it.
							produced = 1'b0;
							res = '0;
							bytes_left = len_acc[15:0];
							parse_phase = (bytes_left != 16'd0) ? PH_PAYLOAD : PH_TCR;
						end
					end
					default: res.status = ST_PROTO;
				endcase
			end
			PH_PAYLOAD: begin
				produced = 1'b1;
				res.item_type = ITEM_PAYLOAD;
				res.payload_byte = b;
				bytes_left = bytes_left - 16'd1;
				if (bytes_left == 16'd0)
					parse_phase = PH_TCR;
			end
			PH_TCR: parse_phase = PH_TLF;
			PH_TLF: begin
				produced = 1'b1;
				res.item_type = ITEM_STATUS;
				res.status = ST_OK;
				res.payload_length = len_acc[15:0];
				parse_phase = PH_IDLE;
			end
			default: parse_phase = PH_IDLE;
		endcase
	endfunction

	task automatic report_field(input string name, input int unsigned want_v,
			input int unsigned got_v);
		if (want_v != got_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Check each result against the oldest one owed, then predict from the accepted request.
	always @(posedge clk or negedge arst_n) begin : watch
		bit          produced;
		rrp_result_t want;
		rrp_result_t got;
		if (!arst_n) begin
			parse_phase = PH_IDLE;
			reply_kind = MK_OTHER;
			req_kind = '0;
			line_len = '0;
			line_flags = '0;
			len_acc = '0;
			bytes_left = '0;
			results_due.delete();
			fail_count = 0;
			pending <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.item_type = m_axis_tuser;
				got.payload_byte = m_axis_tdata[7:0];
				got.status = m_axis_tdata[9:8];
				got.null_reply = m_axis_tdata[10];
				got.payload_length = m_axis_tdata[26:11];
				if (results_due.size() == 0) begin
					$display("%0t: result mismatch, expected none, actual tuser %0h tdata %0h",
						$time, m_axis_tuser, m_axis_tdata);
					fail_count++;
				end else begin
					want = results_due.pop_front();
					report_field("item_type", want.item_type, got.item_type);
					report_field("payload_byte", want.payload_byte, got.payload_byte);
					report_field("status", want.status, got.status);
					report_field("null_reply", want.null_reply, got.null_reply);
					report_field("payload_length", want.payload_length, got.payload_length);
					report_field("tdata padding", 0, m_axis_tdata[rrp_pkg::TDATA_W-1:27]);
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				parse_reply_byte(s_axis_tdata, s_axis_tuser, produced, want);
				if (produced)
					results_due.push_back(want);
			end
			pending <= results_due.size();
		end
	end

endmodule

// File: sim/resp_reply_parser_core_tb.sv
`timescale 1ns / 1ps

module resp_reply_parser_core_tb;

	import rrp_pkg::*;

	localparam logic [7:0] CH_LF          = 8'h0A;
	// A request code that names no request kind.
	localparam logic [2:0] RQ_NONE        = 3'd7;
	localparam int         RX_HOLD_CYCLES = 200;
	localparam int         CYCLE_LIMIT    = 300000;
	localparam int         RANDOM_BYTES   = 600;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  s_axis_tvalid;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata;
	logic [2:0]            s_axis_tuser;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready;
	logic [TDATA_W-1:0]    m_axis_tdata;
	logic                  m_axis_tuser;
	int                    fail_count;
	int                    pending;

	int                    cycle_count = 0;
	int                    items_sent = 0;
	int                    hold_requests = 0;
	int                    tx_fast_left = 0;
	bit                    tx_burst = 1'b0;
	logic [7:0]            reply_bytes[$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	resp_reply_parser_core u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	resp_reply_parser_core_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("resp_reply_parser_core_tb NOT OK");
			$finish;
		end
	end

	// Result sink: random stalls, quiet stretches, and a long hold-off when asked for.
	initial begin : result_sink
		int stall;
		int served;
		int fast_left;
		served = 0;
		fast_left = 0;
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_requests != served) begin
				stall = RX_HOLD_CYCLES;
				served++;
			end else if (fast_left > 0) begin
				stall = 0;
				fast_left--;
			end else begin
				stall = $urandom_range(0, 12);
				if ($urandom_range(0, 39) == 0)
					fast_left = 30;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
		end
	end

	// Offers one byte after a random or zero gap; returns at the edge that accepts it.
	task automatic send_byte(input logic [7:0] b, input logic [2:0] kind);
		int gap;
		if (tx_burst) begin
			gap = 0;
		end else if (tx_fast_left > 0) begin
			gap = 0;
			tx_fast_left--;
		end else begin
			gap = $urandom_range(0, 12);
		end
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tuser <= kind;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
	endtask

	task automatic add_text(input string txt);
		for (int i = 0; i < txt.len(); i++)
			reply_bytes.push_back(txt[i]);
	endtask

	task automatic add_crlf();
		reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
	endtask

	// The request kind rides on the first byte; later bytes carry noise there.
	task automatic send_reply(input logic [2:0] kind);
		foreach (reply_bytes[i])
			send_byte(reply_bytes[i], (i == 0) ? kind : 3'($urandom_range(0, 7)));
		reply_bytes.delete();
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	function automatic logic [2:0] pick_request(input logic [2:0] likely);
		return ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7)) : likely;
	endfunction

	// Reset, directed replies, the pressure phase, random replies, verdict.
	initial begin : stimulus
		int    pick;
		int    sel;
		int    len;
		int    random_end;
		string simple_chars;
		simple_chars = "OKPNGX";
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A CR as the very first byte ends the line at once.
		reply_bytes.push_back(CH_CR);
		reply_bytes.push_back(CH_LF);
		send_reply(RQ_SET);
		add_text("+OK");
		add_crlf();
		send_reply(RQ_AUTH);
		add_text("+PONG");
		add_crlf();
		send_reply(RQ_CHECK);
		add_text(":7");
		add_crlf();
		send_reply(RQ_NONE);
		add_text("-ERR");
		add_crlf();
		send_reply(RQ_DEL);
		add_text("$-1");
		add_crlf();
		send_reply(RQ_GET);
		add_text("$2");
		add_crlf();
		reply_bytes.push_back(8'hFF);
		reply_bytes.push_back(8'h00);
		add_crlf();
		send_reply(RQ_GET);
		add_text("$65536");
		add_crlf();
		send_reply(RQ_GET);
		// A bulk reply to another request: the payload is parsed as a new reply.
		add_text("$1");
		add_crlf();
		add_text(":");
		add_crlf();
		send_reply(RQ_SET);
		add_text("$0");
		add_crlf();
		add_crlf();
		send_reply(RQ_GET);

		// Long hold-off on the result side while bytes keep coming back to back.
		hold_requests++;
		tx_burst = 1'b1;
		add_text("$40");
		add_crlf();
		repeat (40) reply_bytes.push_back(8'($urandom_range(0, 255)));
		add_crlf();
		send_reply(RQ_GET);
		tx_burst = 1'b0;
		wait_drained();

		// Random replies, mostly well formed, with noise and broken lines mixed in.
		random_end = items_sent + RANDOM_BYTES;
		while (items_sent < random_end) begin
			pick = $urandom_range(0, 99);
			if (pick < 15) begin
				reply_bytes.push_back(CH_PLUS);
				case ($urandom_range(0, 3))
					0: add_text("OK");
					1: add_text("PONG");
					default: repeat ($urandom_range(0, 20))
						reply_bytes.push_back(simple_chars[$urandom_range(0, 5)]);
				endcase
				add_crlf();
				send_reply(pick_request(3'($urandom_range(0, 2))));
			end else if (pick < 25) begin
				reply_bytes.push_back(CH_MINUS);
				repeat ($urandom_range(0, 18))
					reply_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
				add_crlf();
				send_reply(3'($urandom_range(0, 7)));
			end else if (pick < 35) begin
				add_text($sformatf(":%0d", $urandom_range(0, 99999)));
				add_crlf();
				send_reply(pick_request(RQ_DEL));
			end else if (pick < 80) begin
				reply_bytes.push_back(CH_DOLLAR);
				sel = $urandom_range(0, 19);
				if (sel < 13 || sel == 19) begin
					len = (sel < 11) ? $urandom_range(0, 12) : $urandom_range(13, 300);
					if (sel == 19)
						add_text("00");
					add_text($sformatf("%0d", len));
					add_crlf();
					repeat (len) reply_bytes.push_back(8'($urandom_range(0, 255)));
					add_crlf();
				end else if (sel < 15) begin
					// Null prefix, possibly with more on the line.
					add_text("-1");
					repeat ($urandom_range(0, 3))
						reply_bytes.push_back(8'($urandom_range(8'h20, 8'h7E)));
					add_crlf();
				end else if (sel == 15) begin
					add_text($sformatf("%0d", $urandom_range(65536, 9999999)));
					add_crlf();
				end else if (sel == 16) begin
					add_text($sformatf("%0dx", $urandom_range(0, 9)));
					add_crlf();
				end else if (sel == 17) begin
					add_crlf();
				end else begin
					add_text($sformatf("-%0d", $urandom_range(2, 9)));
					add_crlf();
				end
				send_reply(pick_request(RQ_GET));
			end else if (pick < 95) begin
				repeat ($urandom_range(1, 6))
					reply_bytes.push_back(8'($urandom_range(0, 255)));
				send_reply(3'($urandom_range(0, 7)));
			end else if (pick < 98) begin
				wait_drained();
			end else begin
				tx_fast_left = 30;
			end
		end

		// Let every owed result arrive, then watch a while for stray ones.
		wait_drained();
		repeat (40) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("resp_reply_parser_core_tb OK");
		else
			$display("resp_reply_parser_core_tb NOT OK");
		$finish;
	end

endmodule
